/* src/perspective_warp_coordinate_mapper_top_assert.svh */
// ----------------------------------------------------------------------------
// perspective warp coordinate mapper - assertion macros
// clocked property macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef PERSPECTIVE_WARP_COORDINATE_MAPPER_TOP_ASSERT_SVH
`define PERSPECTIVE_WARP_COORDINATE_MAPPER_TOP_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define PWCM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define PWCM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/pwcm_pkg.sv */
// ----------------------------------------------------------------------------
// pwcm_pkg
// shared types and constants of the perspective warp coordinate mapper
// ----------------------------------------------------------------------------
package pwcm_pkg;

  // fixed field widths
  localparam int SIZE_BITS = 12;
  localparam int KW        = 2 * SIZE_BITS;
  localparam int SRC_W     = 16;
  localparam int STATUS_W  = 2;
  localparam int QUOT_BITS = 16;
  localparam int CFG_IDX_W = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CORNER_A   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CORNER_B   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CORNER_C   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CORNER_D   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_HEIGHT = 3'd5;

  // size register reset values
  localparam logic [SIZE_BITS-1:0] WIDTH_RESET  = 12'd595;
  localparam logic [SIZE_BITS-1:0] HEIGHT_RESET = 12'd842;

  // quotient clamp limits (magnitudes) and coordinate bounds
  localparam logic [QUOT_BITS-1:0] LIM_POS = 16'd32767;
  localparam logic [QUOT_BITS-1:0] LIM_NEG = 16'd32768;
  localparam logic signed [SRC_W-1:0] SRC_MAX = 16'sh7fff;
  localparam logic signed [SRC_W-1:0] SRC_MIN = 16'sh8000;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_DEGEN    = 2'd1,
    STATUS_ZERO_DEN = 2'd2,
    STATUS_SAT      = 2'd3
  } status_t;

  // coefficient derivation sequence
  typedef enum logic [2:0] {
    DER_DIFF,
    DER_CROSS,
    DER_DET,
    DER_SCALE,
    DER_COEF,
    DER_READY
  } der_state_t;

  typedef struct packed {
    logic [SIZE_BITS-1:0] pixel_x;
    logic [SIZE_BITS-1:0] pixel_y;
  } pixel_req_t;

  typedef struct packed {
    logic signed [SRC_W-1:0] source_x;
    logic signed [SRC_W-1:0] source_y;
    status_t                 status;
  } source_resp_t;

  // per-request flags carried beside the divider data
  typedef struct packed {
    logic neg_x;
    logic neg_y;
    logic ovf_x;
    logic ovf_y;
    logic zero_den;
    logic degen;
  } div_flags_t;

endpackage

/* src/pwcm_divider.sv */
// ----------------------------------------------------------------------------
// pwcm_divider
// pipelined restoring divider, one quotient bit per stage for x and y
// ----------------------------------------------------------------------------
module pwcm_divider import pwcm_pkg::*; #(
  parameter int NW = 65
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [NW-1:0]        in_mag_x,
  input  logic [NW-1:0]        in_mag_y,
  input  logic [NW-1:0]        in_den,
  input  div_flags_t           in_flags,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [QUOT_BITS-1:0] out_quot_x,
  output logic [QUOT_BITS-1:0] out_quot_y,
  output div_flags_t           out_flags
);

  localparam int XW   = NW + QUOT_BITS;
  localparam int LAST = QUOT_BITS - 1;

  // stage registers
  logic                 v_r   [QUOT_BITS];
  logic [NW-1:0]        rx_r  [QUOT_BITS];
  logic [NW-1:0]        ry_r  [QUOT_BITS];
  logic [NW-1:0]        den_r [QUOT_BITS];
  logic [QUOT_BITS-1:0] qx_r  [QUOT_BITS];
  logic [QUOT_BITS-1:0] qy_r  [QUOT_BITS];
  div_flags_t           fl_r  [QUOT_BITS];

  // stage inputs and hold chain
  logic                 v_in   [QUOT_BITS];
  logic [NW-1:0]        rx_in  [QUOT_BITS];
  logic [NW-1:0]        ry_in  [QUOT_BITS];
  logic [NW-1:0]        den_in [QUOT_BITS];
  logic [QUOT_BITS-1:0] qx_in  [QUOT_BITS];
  logic [QUOT_BITS-1:0] qy_in  [QUOT_BITS];
  div_flags_t           fl_in  [QUOT_BITS];
  logic                 busy   [QUOT_BITS];

  for (genvar s = 0; s < QUOT_BITS; s++) begin : g_stage
    localparam int B = LAST - s;

    logic [XW-1:0]        shifted;
    logic                 take_x;
    logic                 take_y;
    logic [NW-1:0]        rx_nxt;
    logic [NW-1:0]        ry_nxt;
    logic [QUOT_BITS-1:0] qx_nxt;
    logic [QUOT_BITS-1:0] qy_nxt;

    // source of this stage
    if (s == 0) begin : g_first
      assign v_in[s]   = in_valid;
      assign rx_in[s]  = in_mag_x;
      assign ry_in[s]  = in_mag_y;
      assign den_in[s] = in_den;
      assign qx_in[s]  = '0;
      assign qy_in[s]  = '0;
      assign fl_in[s]  = in_flags;
    end else begin : g_next
      assign v_in[s]   = v_r[s-1];
      assign rx_in[s]  = rx_r[s-1];
      assign ry_in[s]  = ry_r[s-1];
      assign den_in[s] = den_r[s-1];
      assign qx_in[s]  = qx_r[s-1];
      assign qy_in[s]  = qy_r[s-1];
      assign fl_in[s]  = fl_r[s-1];
    end

    // stage holds while occupied and the next one holds
    if (s == LAST) begin : g_tail
      assign busy[s] = v_r[s] & out_stall;
    end else begin : g_body
      assign busy[s] = v_r[s] & busy[s+1];
    end

    // trial subtract of the shifted divisor
    always_comb begin
      shifted = XW'(den_in[s]) << B;
      take_x  = XW'(rx_in[s]) >= shifted;
      take_y  = XW'(ry_in[s]) >= shifted;
      rx_nxt  = take_x ? NW'(XW'(rx_in[s]) - shifted) : rx_in[s];
      ry_nxt  = take_y ? NW'(XW'(ry_in[s]) - shifted) : ry_in[s];
      qx_nxt  = qx_in[s];
      qy_nxt  = qy_in[s];
      qx_nxt[B] = take_x;
      qy_nxt[B] = take_y;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (!busy[s]) begin
        v_r[s] <= v_in[s];
      end
    end

    always_ff @(posedge clk) begin
      if (!busy[s]) begin
        rx_r[s]  <= rx_nxt;
        ry_r[s]  <= ry_nxt;
        den_r[s] <= den_in[s];
        qx_r[s]  <= qx_nxt;
        qy_r[s]  <= qy_nxt;
        fl_r[s]  <= fl_in[s];
      end
    end
  end

  assign in_stall   = busy[0];
  assign out_valid  = v_r[LAST];
  assign out_quot_x = qx_r[LAST];
  assign out_quot_y = qy_r[LAST];
  assign out_flags  = fl_r[LAST];

endmodule

/* src/perspective_warp_coordinate_mapper_top.sv */
// ----------------------------------------------------------------------------
// perspective_warp_coordinate_mapper_top
// inverse square-to-quad mapping of output pixels onto source coordinates
// ----------------------------------------------------------------------------
// Takes one pixel request per clock and returns one source coordinate per
// clock while neither side stalls, in order, after the six arithmetic stages,
// the sixteen-stage divider that yields one quotient bit per stage, and the
// output register. After reset and after every write to a used register
// index the mapping coefficients are derived by a short sequencer with its
// own multipliers; in_stall stays high during that time, and configuration
// writes are always taken (cfg_ready is held high). A stall on the result
// side holds only the occupied stages, so empty stages keep filling.
module perspective_warp_coordinate_mapper_top import pwcm_pkg::*; #(
  parameter int COORD_BITS = 12
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  pixel_req_t              in_data,
  output logic                    out_valid,
  input  logic                    out_stall,
  output source_resp_t            out_data,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [2*COORD_BITS-1:0] cfg_wdata
);

  localparam int C   = COORD_BITS;
  localparam int DW  = C + 1;
  localparam int SXW = C + 2;
  localparam int GW  = 2 * C + 4;
  localparam int SPW = 3 * C + 5;
  localparam int CW  = 3 * C + 3;
  localparam int LO  = CW / 2;
  localparam int HI  = CW - LO;
  localparam int PLW = LO + KW;
  localparam int PHW = HI + KW + 1;
  localparam int PW  = CW + KW + 1;
  localparam int NW  = CW + KW + 2;
  localparam int XW  = NW + QUOT_BITS;

  // configuration registers
  logic [2*C-1:0]       corner_r [4];
  logic [SIZE_BITS-1:0] width_r;
  logic [SIZE_BITS-1:0] height_r;
  logic                 cfg_we;
  logic                 cfg_hit;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid & cfg_ready;
  assign cfg_hit   = cfg_index <= REG_OUT_HEIGHT;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) corner_r[i] <= '0;
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CORNER_A:   corner_r[0] <= cfg_wdata;
        REG_CORNER_B:   corner_r[1] <= cfg_wdata;
        REG_CORNER_C:   corner_r[2] <= cfg_wdata;
        REG_CORNER_D:   corner_r[3] <= cfg_wdata;
        REG_OUT_WIDTH:  width_r     <= cfg_wdata[SIZE_BITS-1:0];
        REG_OUT_HEIGHT: height_r    <= cfg_wdata[SIZE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // zero size counts as one
  logic [SIZE_BITS-1:0] w_eff;
  logic [SIZE_BITS-1:0] h_eff;
  assign w_eff = (width_r == '0)  ? SIZE_BITS'(1) : width_r;
  assign h_eff = (height_r == '0) ? SIZE_BITS'(1) : height_r;

  // corner coordinates as signed values
  logic signed [DW-1:0] xs [4];
  logic signed [DW-1:0] ys [4];
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      xs[i] = $signed({1'b0, corner_r[i][C-1:0]});
      ys[i] = $signed({1'b0, corner_r[i][2*C-1:C]});
    end
  end

  // derivation sequencer
  der_state_t der_r;
  der_state_t der_nxt;
  logic       ld_diff;
  logic       ld_cross;
  logic       ld_det;
  logic       ld_scale;
  logic       ld_coef;
  logic       coef_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      der_r <= DER_DIFF;
    end else begin
      der_r <= der_nxt;
    end
  end

  // next state
  always_comb begin
    der_nxt = der_r;
    if (cfg_we && cfg_hit) begin
      der_nxt = DER_DIFF;
    end else begin
      unique case (der_r)
        DER_DIFF:  der_nxt = DER_CROSS;
        DER_CROSS: der_nxt = DER_DET;
        DER_DET:   der_nxt = DER_SCALE;
        DER_SCALE: der_nxt = DER_COEF;
        DER_COEF:  der_nxt = DER_READY;
        DER_READY: der_nxt = DER_READY;
        default:   der_nxt = DER_DIFF;
      endcase
    end
  end

  // state outputs
  always_comb begin
    ld_diff    = 1'b0;
    ld_cross   = 1'b0;
    ld_det     = 1'b0;
    ld_scale   = 1'b0;
    ld_coef    = 1'b0;
    coef_ready = 1'b0;
    unique case (der_r)
      DER_DIFF:  ld_diff    = 1'b1;
      DER_CROSS: ld_cross   = 1'b1;
      DER_DET:   ld_det     = 1'b1;
      DER_SCALE: ld_scale   = 1'b1;
      DER_COEF:  ld_coef    = 1'b1;
      DER_READY: coef_ready = 1'b1;
      default: ;
    endcase
  end

  // edge differences and parallelogram sums
  logic signed [SXW-1:0] sx_r, sy_r;
  logic signed [DW-1:0]  ex1_r, ex2_r, ey1_r, ey2_r;
  logic signed [DW-1:0]  dx10_r, dx30_r, dy10_r, dy30_r;

  always_ff @(posedge clk) begin
    if (ld_diff) begin
      sx_r   <= SXW'(xs[0] - xs[1] + xs[2] - xs[3]);
      sy_r   <= SXW'(ys[0] - ys[1] + ys[2] - ys[3]);
      ex1_r  <= DW'(xs[1] - xs[2]);
      ex2_r  <= DW'(xs[3] - xs[2]);
      ey1_r  <= DW'(ys[1] - ys[2]);
      ey2_r  <= DW'(ys[3] - ys[2]);
      dx10_r <= DW'(xs[1] - xs[0]);
      dx30_r <= DW'(xs[3] - xs[0]);
      dy10_r <= DW'(ys[1] - ys[0]);
      dy30_r <= DW'(ys[3] - ys[0]);
    end
  end

  // cross products and the size product
  logic signed [GW-1:0] pa_r, pb_r, pc_r, pd_r, pe_r, pf_r;
  logic [KW-1:0]        kc_r;

  always_ff @(posedge clk) begin
    if (ld_cross) begin
      pa_r <= GW'(ex1_r * ey2_r);
      pb_r <= GW'(ex2_r * ey1_r);
      pc_r <= GW'(sx_r * ey2_r);
      pd_r <= GW'(ex2_r * sy_r);
      pe_r <= GW'(ex1_r * sy_r);
      pf_r <= GW'(sx_r * ey1_r);
      kc_r <= KW'(w_eff * h_eff);
    end
  end

  // determinant and projective terms
  logic signed [GW-1:0] det_r, g_r, h_r;

  always_ff @(posedge clk) begin
    if (ld_det) begin
      det_r <= pa_r - pb_r;
      g_r   <= pc_r - pd_r;
      h_r   <= pe_r - pf_r;
    end
  end

  // products scaled by the determinant
  logic signed [SPW-1:0] sc_r [10];

  always_ff @(posedge clk) begin
    if (ld_scale) begin
      sc_r[0] <= SPW'(dx10_r * det_r);
      sc_r[1] <= SPW'(g_r * xs[1]);
      sc_r[2] <= SPW'(dx30_r * det_r);
      sc_r[3] <= SPW'(h_r * xs[3]);
      sc_r[4] <= SPW'(xs[0] * det_r);
      sc_r[5] <= SPW'(dy10_r * det_r);
      sc_r[6] <= SPW'(g_r * ys[1]);
      sc_r[7] <= SPW'(dy30_r * det_r);
      sc_r[8] <= SPW'(h_r * ys[3]);
      sc_r[9] <= SPW'(ys[0] * det_r);
    end
  end

  // coefficient selection: affine, degenerate or projective
  logic signed [CW-1:0] coef_r   [9];
  logic signed [CW-1:0] coef_nxt [9];
  logic                 degen_nxt;
  logic                 degenerate_r;

  always_comb begin
    degen_nxt = 1'b0;
    for (int k = 0; k < 9; k++) coef_nxt[k] = '0;
    if (sx_r == '0 && sy_r == '0) begin
      coef_nxt[0] = CW'(dx10_r);
      coef_nxt[1] = CW'(-ex1_r);
      coef_nxt[2] = CW'(xs[0]);
      coef_nxt[3] = CW'(dy10_r);
      coef_nxt[4] = CW'(-ey1_r);
      coef_nxt[5] = CW'(ys[0]);
      coef_nxt[8] = {{(CW-1){1'b0}}, 1'b1};
    end else if (det_r == '0) begin
      degen_nxt = 1'b1;
    end else begin
      coef_nxt[0] = CW'(sc_r[0] + sc_r[1]);
      coef_nxt[1] = CW'(sc_r[2] + sc_r[3]);
      coef_nxt[2] = CW'(sc_r[4]);
      coef_nxt[3] = CW'(sc_r[5] + sc_r[6]);
      coef_nxt[4] = CW'(sc_r[7] + sc_r[8]);
      coef_nxt[5] = CW'(sc_r[9]);
      coef_nxt[6] = CW'(g_r);
      coef_nxt[7] = CW'(h_r);
      coef_nxt[8] = CW'(det_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      degenerate_r <= 1'b0;
    end else if (ld_coef) begin
      degenerate_r <= degen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_coef) begin
      for (int k = 0; k < 9; k++) coef_r[k] <= coef_nxt[k];
    end
  end

  // ---------------------------------------------------------------------------
  // pixel pipeline
  // ---------------------------------------------------------------------------
  logic va_r, vb_r, vc_r, vd_r, ve_r, vf_r, vo_r;
  logic busy_a, busy_b, busy_c, busy_d, busy_e, busy_f, busy_o;
  logic div_in_stall;
  logic div_out_valid;
  logic accept;

  // hold chain from the result side back to the request side
  assign busy_o = vo_r & out_stall;
  assign busy_f = vf_r & div_in_stall;
  assign busy_e = ve_r & busy_f;
  assign busy_d = vd_r & busy_e;
  assign busy_c = vc_r & busy_d;
  assign busy_b = vb_r & busy_c;
  assign busy_a = va_r & busy_b;

  assign in_stall = busy_a | ~coef_ready;
  assign accept   = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
      ve_r <= 1'b0;
      vf_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (!busy_a) va_r <= accept;
      if (!busy_b) vb_r <= va_r;
      if (!busy_c) vc_r <= vb_r;
      if (!busy_d) vd_r <= vc_r;
      if (!busy_e) ve_r <= vd_r;
      if (!busy_f) vf_r <= ve_r;
      if (!busy_o) vo_r <= div_out_valid;
    end
  end

  // stage a: scaled pixel terms
  logic [KW-1:0] ku_r, kv_r;

  always_ff @(posedge clk) begin
    if (!busy_a) begin
      ku_r <= KW'(in_data.pixel_x * h_eff);
      kv_r <= KW'(in_data.pixel_y * w_eff);
    end
  end

  // stages b and c: split coefficient products, then recombination
  logic [PLW-1:0]        plo_r  [9];
  logic signed [PHW-1:0] phi_r  [9];
  logic signed [PW-1:0]  prod_r [9];

  for (genvar j = 0; j < 9; j++) begin : g_prod
    logic [KW-1:0] kj;

    if (j % 3 == 0) begin : g_ku
      assign kj = ku_r;
    end else if (j % 3 == 1) begin : g_kv
      assign kj = kv_r;
    end else begin : g_kc
      assign kj = kc_r;
    end

    always_ff @(posedge clk) begin
      if (!busy_b) begin
        plo_r[j] <= PLW'(coef_r[j][LO-1:0] * kj);
        phi_r[j] <= PHW'($signed(coef_r[j][CW-1:LO]) * $signed({1'b0, kj}));
      end
    end

    always_ff @(posedge clk) begin
      if (!busy_c) begin
        prod_r[j] <= (PW'(phi_r[j]) <<< LO) + PW'(plo_r[j]);
      end
    end
  end

  // stage d: numerators and denominator
  logic signed [NW-1:0] nx_r, ny_r, dn_r;

  always_ff @(posedge clk) begin
    if (!busy_d) begin
      nx_r <= NW'(prod_r[0]) + NW'(prod_r[1]) + NW'(prod_r[2]);
      ny_r <= NW'(prod_r[3]) + NW'(prod_r[4]) + NW'(prod_r[5]);
      dn_r <= NW'(prod_r[6]) + NW'(prod_r[7]) + NW'(prod_r[8]);
    end
  end

  // stage e: magnitudes, quotient signs, special cases
  logic [NW-1:0] mxe_r, mye_r, mde_r;
  div_flags_t    fle_r;

  always_ff @(posedge clk) begin
    if (!busy_e) begin
      mxe_r          <= nx_r[NW-1] ? NW'(-nx_r) : NW'(nx_r);
      mye_r          <= ny_r[NW-1] ? NW'(-ny_r) : NW'(ny_r);
      mde_r          <= dn_r[NW-1] ? NW'(-dn_r) : NW'(dn_r);
      fle_r.neg_x    <= nx_r[NW-1] ^ dn_r[NW-1];
      fle_r.neg_y    <= ny_r[NW-1] ^ dn_r[NW-1];
      fle_r.ovf_x    <= 1'b0;
      fle_r.ovf_y    <= 1'b0;
      fle_r.zero_den <= dn_r == '0;
      fle_r.degen    <= degenerate_r;
    end
  end

  // stage f: quotient too large for sixteen bits
  logic [NW-1:0] mxf_r, myf_r, mdf_r;
  div_flags_t    flf_r;
  div_flags_t    flf_nxt;

  always_comb begin
    flf_nxt       = fle_r;
    flf_nxt.ovf_x = XW'(mxe_r) >= (XW'(mde_r) << QUOT_BITS);
    flf_nxt.ovf_y = XW'(mye_r) >= (XW'(mde_r) << QUOT_BITS);
  end

  always_ff @(posedge clk) begin
    if (!busy_f) begin
      mxf_r <= mxe_r;
      myf_r <= mye_r;
      mdf_r <= mde_r;
      flf_r <= flf_nxt;
    end
  end

  // divider
  logic [QUOT_BITS-1:0] qx, qy;
  div_flags_t           fl_q;

  pwcm_divider #(
    .NW (NW)
  ) u_divider (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (vf_r),
    .in_stall   (div_in_stall),
    .in_mag_x   (mxf_r),
    .in_mag_y   (myf_r),
    .in_den     (mdf_r),
    .in_flags   (flf_r),
    .out_valid  (div_out_valid),
    .out_stall  (busy_o),
    .out_quot_x (qx),
    .out_quot_y (qy),
    .out_flags  (fl_q)
  );

  // clamp, sign and status
  logic [QUOT_BITS-1:0] lim_x, lim_y, mag_x, mag_y;
  logic                 sat_x, sat_y;
  source_resp_t         resp_nxt;
  source_resp_t         out_data_r;

  always_comb begin
    lim_x = fl_q.neg_x ? LIM_NEG : LIM_POS;
    lim_y = fl_q.neg_y ? LIM_NEG : LIM_POS;
    sat_x = fl_q.ovf_x | (qx > lim_x);
    sat_y = fl_q.ovf_y | (qy > lim_y);
    mag_x = sat_x ? lim_x : qx;
    mag_y = sat_y ? lim_y : qy;
    priority if (fl_q.degen) begin
      resp_nxt = '{source_x: '0, source_y: '0, status: STATUS_DEGEN};
    end else if (fl_q.zero_den) begin
      resp_nxt = '{source_x: '0, source_y: '0, status: STATUS_ZERO_DEN};
    end else begin
      resp_nxt.source_x = fl_q.neg_x ? $signed(-mag_x) : $signed(mag_x);
      resp_nxt.source_y = fl_q.neg_y ? $signed(-mag_y) : $signed(mag_y);
      resp_nxt.status   = (sat_x | sat_y) ? STATUS_SAT : STATUS_OK;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!busy_o) begin
      out_data_r <= resp_nxt;
    end
  end

  assign out_valid = vo_r;
  assign out_data  = out_data_r;

endmodule

/* src/pwcm_checker.sv */
// ----------------------------------------------------------------------------
// pwcm_checker
// port-level checks of the perspective warp coordinate mapper
// ----------------------------------------------------------------------------
`include "perspective_warp_coordinate_mapper_top_assert.svh"

module pwcm_checker import pwcm_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_stall,
  input logic                 cfg_valid,
  input logic                 cfg_ready,
  input logic [CFG_IDX_W-1:0] cfg_index,
  input logic                 out_valid,
  input logic                 out_stall,
  input source_resp_t         out_data
);

  // a held result stays put
  `PWCM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "result changed while stalled")

  // a write to a used register index restarts the coefficient derivation
  `PWCM_ASSERT_NEXT(a_cfg_rederive, cfg_valid && cfg_ready && cfg_index <= REG_OUT_HEIGHT, in_stall, "request taken before coefficients were rederived")

  // degenerate corners give a zero coordinate
  `PWCM_ASSERT_SAME(a_degen_zero, out_valid && out_data.status == STATUS_DEGEN, out_data.source_x == '0 && out_data.source_y == '0, "degenerate result not zero")

  // zero denominator gives a zero coordinate
  `PWCM_ASSERT_SAME(a_zden_zero, out_valid && out_data.status == STATUS_ZERO_DEN, out_data.source_x == '0 && out_data.source_y == '0, "zero denominator result not zero")

  // saturation leaves one coordinate on a bound
  `PWCM_ASSERT_SAME(a_sat_bound, out_valid && out_data.status == STATUS_SAT, out_data.source_x == SRC_MAX || out_data.source_x == SRC_MIN || out_data.source_y == SRC_MAX || out_data.source_y == SRC_MIN, "saturated result not on a bound")

endmodule

bind perspective_warp_coordinate_mapper_top pwcm_checker u_pwcm_checker (.*);

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the perspective warp coordinate mapper: the corners
// and output size are set while the block is idle, pixel requests are sent in
// bursts, and each returned source coordinate is checked against an in-bench
// copy of the square-to-quad mapping worked out in exact integer arithmetic
// ----------------------------------------------------------------------------
module tb;
  import pwcm_pkg::*;

  localparam int CLK_PERIOD = 8;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT = 600000;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  pixel_req_t in_data;
  logic out_valid;
  logic out_stall;
  source_resp_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [23:0] cfg_wdata;

  // bench copy of the register file
  logic [23:0] corner_reg [4];
  logic [SIZE_BITS-1:0] width_reg;
  logic [SIZE_BITS-1:0] height_reg;

  pixel_req_t pixel_q[$];
  source_resp_t source_q[$];
  int errors;
  int cycles;
  bit req_taken;
  int gap_left;
  int burst_left;
  int stall_mode;

  perspective_warp_coordinate_mapper_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // truncating quotient clamped to the signed 16-bit coordinate range
  function automatic logic [SRC_W-1:0] clamp_quotient(logic signed [127:0] num,
                                                      logic signed [127:0] den,
                                                      inout bit sat);
    logic signed [127:0] q;
    q = num / den;
    if (q > 32767) begin
      sat = 1'b1;
      return SRC_MAX;
    end
    if (q < -32768) begin
      sat = 1'b1;
      return SRC_MIN;
    end
    return q[SRC_W-1:0];
  endfunction

  // source coordinate of one output pixel under the current registers
  function automatic source_resp_t map_pixel(logic [SIZE_BITS-1:0] px,
                                             logic [SIZE_BITS-1:0] py);
    longint xs [4];
    longint ys [4];
    longint m [9];
    longint sx, sy, ex1, ex2, ey1, ey2, det, g, h;
    logic [SIZE_BITS:0] wv, hv;
    logic signed [127:0] ku, kv, kc, nx, ny, dn;
    source_resp_t r;
    bit sat;
    bit degen;
    sat = 1'b0;
    degen = 1'b0;
    for (int k = 0; k < 4; k++) begin
      xs[k] = corner_reg[k][11:0];
      ys[k] = corner_reg[k][23:12];
    end
    for (int k = 0; k < 9; k++) m[k] = 0;
    sx = xs[0] - xs[1] + xs[2] - xs[3];
    sy = ys[0] - ys[1] + ys[2] - ys[3];
    if (sx == 0 && sy == 0) begin
      // parallelogram: plain affine map
      m[0] = xs[1] - xs[0]; m[1] = xs[2] - xs[1]; m[2] = xs[0];
      m[3] = ys[1] - ys[0]; m[4] = ys[2] - ys[1]; m[5] = ys[0];
      m[8] = 1;
    end else begin
      ex1 = xs[1] - xs[2]; ex2 = xs[3] - xs[2];
      ey1 = ys[1] - ys[2]; ey2 = ys[3] - ys[2];
      det = ex1 * ey2 - ex2 * ey1;
      if (det == 0) begin
        degen = 1'b1;
      end else begin
        g = sx * ey2 - ex2 * sy;
        h = ex1 * sy - sx * ey1;
        m[0] = (xs[1] - xs[0]) * det + g * xs[1];
        m[1] = (xs[3] - xs[0]) * det + h * xs[3];
        m[2] = xs[0] * det;
        m[3] = (ys[1] - ys[0]) * det + g * ys[1];
        m[4] = (ys[3] - ys[0]) * det + h * ys[3];
        m[5] = ys[0] * det;
        m[6] = g; m[7] = h; m[8] = det;
      end
    end
    r.source_x = '0;
    r.source_y = '0;
    if (degen) begin
      r.status = STATUS_DEGEN;
      return r;
    end
    wv = (width_reg == '0) ? (SIZE_BITS+1)'(1) : {1'b0, width_reg};
    hv = (height_reg == '0) ? (SIZE_BITS+1)'(1) : {1'b0, height_reg};
    ku = px * hv;
    kv = py * wv;
    kc = wv * hv;
    dn = m[6] * ku + m[7] * kv + m[8] * kc;
    if (dn == 0) begin
      r.status = STATUS_ZERO_DEN;
      return r;
    end
    nx = m[0] * ku + m[1] * kv + m[2] * kc;
    ny = m[3] * ku + m[4] * kv + m[5] * kc;
    r.source_x = clamp_quotient(nx, dn, sat);
    r.source_y = clamp_quotient(ny, dn, sat);
    r.status = sat ? STATUS_SAT : STATUS_OK;
    return r;
  endfunction

  // request acceptance: record expected coordinate
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      source_q.insert(source_q.size(), map_pixel(in_data.pixel_x, in_data.pixel_y));
      void'(pixel_q.pop_front());
      req_taken = 1'b1;
    end
  end

  // request driver, bursts with random gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !req_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pixel_q.size() > 0) begin
        in_valid <= 1'b1;
        in_data <= pixel_q[0];
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
    req_taken = 1'b0;
  end

  // result side stall pattern: none, light or heavy, switching now and then
  always @(negedge clk) begin
    if (cycles % 97 == 0) stall_mode = $urandom_range(0, 2);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 9) < 3);
      default: out_stall <= ($urandom_range(0, 9) < 7);
    endcase
  end

  // result checker
  always @(posedge clk) begin
    source_resp_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (source_q.size() == 0) begin
        $error("unexpected result %h", out_data);
        errors++;
      end else begin
        exp_r = source_q.pop_front();
        if (out_data.source_x !== exp_r.source_x) begin
          $error("source_x expected %0d actual %0d", exp_r.source_x, out_data.source_x);
          errors++;
        end
        if (out_data.source_y !== exp_r.source_y) begin
          $error("source_y expected %0d actual %0d", exp_r.source_y, out_data.source_y);
          errors++;
        end
        if (out_data.status !== exp_r.status) begin
          $error("status expected %0d actual %0d", exp_r.status, out_data.status);
          errors++;
        end
      end
    end
  end

  // run watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [23:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_CORNER_A: corner_reg[0] = data;
      REG_CORNER_B: corner_reg[1] = data;
      REG_CORNER_C: corner_reg[2] = data;
      REG_CORNER_D: corner_reg[3] = data;
      REG_OUT_WIDTH: width_reg = data[SIZE_BITS-1:0];
      REG_OUT_HEIGHT: height_reg = data[SIZE_BITS-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [23:0] pt(int x, int y);
    return {y[11:0], x[11:0]};
  endfunction

  // size written with junk in the unused upper bits
  task automatic set_quad(logic [23:0] a, logic [23:0] b, logic [23:0] c,
                          logic [23:0] d, int w, int h);
    write_reg(REG_CORNER_A, a);
    write_reg(REG_CORNER_B, b);
    write_reg(REG_CORNER_C, c);
    write_reg(REG_CORNER_D, d);
    write_reg(REG_OUT_WIDTH, {12'($urandom), w[11:0]});
    write_reg(REG_OUT_HEIGHT, {12'($urandom), h[11:0]});
  endtask

  task automatic push_pixel(int x, int y);
    pixel_req_t p;
    p.pixel_x = x[11:0];
    p.pixel_y = y[11:0];
    pixel_q.insert(pixel_q.size(), p);
  endtask

  task automatic wait_idle();
    while (pixel_q.size() > 0 || in_valid || source_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // random pixels, mostly inside or just past the output frame
  task automatic random_pixels(int n);
    int wl, hl;
    wl = (width_reg == 0) ? 1 : width_reg;
    hl = (height_reg == 0) ? 1 : height_reg;
    wl = (wl + wl / 4 > 4095) ? 4095 : wl + wl / 4;
    hl = (hl + hl / 4 > 4095) ? 4095 : hl + hl / 4;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 4) == 0) push_pixel($urandom, $urandom);
      else push_pixel($urandom_range(0, wl), $urandom_range(0, hl));
    end
  endtask

  // random corners: parallelogram, free quad, degenerate or bow-tie
  task automatic random_setup();
    int ax, ay, d1x, d1y, d2x, d2y, w, h;
    ax = $urandom_range(1024, 3071);
    ay = $urandom_range(1024, 3071);
    d1x = $urandom_range(0, 1000) - 500;
    d1y = $urandom_range(0, 1000) - 500;
    d2x = $urandom_range(0, 1000) - 500;
    d2y = $urandom_range(0, 1000) - 500;
    case ($urandom_range(0, 5))
      0: begin
        w = $urandom_range(0, 4095);
        h = $urandom_range(0, 4095);
      end
      1, 2: begin
        w = $urandom_range(0, 16);
        h = $urandom_range(0, 16);
      end
      default: begin
        w = $urandom_range(1, 900);
        h = $urandom_range(1, 900);
      end
    endcase
    case ($urandom_range(0, 5))
      0: set_quad(pt(ax, ay), pt(ax + d1x, ay + d1y), pt(ax + d1x + d2x, ay + d1y + d2y),
                  pt(ax + d2x, ay + d2y), w, h);
      1: set_quad(pt($urandom, $urandom), pt(ax, ay), pt(ax + d1x, ay + d1y),
                  pt(ax + 2 * d1x, ay + 2 * d1y), w, h);
      2: set_quad(pt(ax, ay), pt(ax + d1x, ay + d1y), pt(ax + d2x, ay + d2y),
                  pt(ax + d1x + d2x, ay + d1y + d2y), w, h);
      default: set_quad($urandom, $urandom, $urandom, $urandom, w, h);
    endcase
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_CORNER_A;
    cfg_wdata = '0;
    errors = 0;
    cycles = 0;
    req_taken = 1'b0;
    gap_left = 0;
    burst_left = 1;
    stall_mode = 0;
    for (int k = 0; k < 4; k++) corner_reg[k] = '0;
    width_reg = WIDTH_RESET;
    height_reg = HEIGHT_RESET;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset registers: all corners at the origin
    push_pixel(0, 0);
    push_pixel(4095, 4095);
    push_pixel(594, 841);
    wait_idle();

    // rectangle, unit frame, far pixels saturate
    set_quad(pt(100, 50), pt(500, 50), pt(500, 700), pt(100, 700), 1, 1);
    push_pixel(0, 0);
    push_pixel(1, 1);
    push_pixel(4095, 0);
    push_pixel(0, 4095);
    wait_idle();

    // full span corners with zero size treated as one
    set_quad(24'hFFFFFF, pt(0, 4095), 24'h000000, pt(4095, 0), 0, 0);
    push_pixel(0, 0);
    push_pixel(1, 0);
    push_pixel(4095, 4095);
    wait_idle();

    // bow-tie: denominator zero on row one, huge values beside it
    set_quad(pt(0, 0), pt(2, 0), pt(0, 2), pt(2, 2), 2, 2);
    push_pixel(0, 1);
    push_pixel(4095, 1);
    push_pixel(0, 0);
    push_pixel(3, 2);
    push_pixel(1, 3);
    wait_idle();

    // three collinear corners: degenerate mapping
    set_quad(pt(0, 5), pt(10, 10), pt(20, 20), pt(30, 30), 4095, 4095);
    push_pixel(7, 9);
    push_pixel(4095, 4095);
    wait_idle();

    // writes to unused indexes leave the mapping alone
    write_reg(REG_SPARE_6, 24'hFFFFFF);
    write_reg(REG_SPARE_7, 24'h123456);
    set_quad(pt(300, 200), pt(3900, 400), pt(3500, 3800), pt(150, 3300), 4095, 4095);
    push_pixel(0, 0);
    push_pixel(4095, 4095);
    push_pixel(2048, 1024);
    wait_idle();

    // random phases
    for (int ph = 0; ph < 26; ph++) begin
      random_setup();
      random_pixels(50);
      wait_idle();
    end

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* perspective_warp_coordinate_mapper_top.f */
+incdir+src
src/pwcm_pkg.sv
src/pwcm_divider.sv
src/perspective_warp_coordinate_mapper_top.sv
src/pwcm_checker.sv
tb/sv/tb.sv
